// ----- src/assert_macros.svh -----
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// types, constants and control structs shared by the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // field widths
  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int CELL_W      = 16;
  localparam int COLOUR_W    = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_COLOUR = 1'b1;

  // character codes and reset colours
  localparam logic [CHAR_W-1:0]   NEWLINE_CODE        = 8'h0A;
  localparam logic [CHAR_W-1:0]   SPACE_CODE          = 8'h20;
  localparam logic [COLOUR_W-1:0] RESET_TEXT_COLOUR   = 8'h07;
  localparam logic [COLOUR_W-1:0] RESET_SCROLL_COLOUR = 8'h02;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_column;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [CELL_W-1:0]      cell_entry;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic                   scrolled;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic put_exec;
    logic read_issue;
    logic sweep_start;
    logic fill_all;
    logic sweep_step;
    logic emit;
    logic emit_read;
    logic emit_scrolled;
    logic home;
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             put_scroll;
    logic             sweep_last;
  } dp_stat_t;

endpackage

// ----- src/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// text console engine: screen of character cells with cursor, put, clear, read
// ----------------------------------------------------------------------------
//  channel   ports                             handshake
//  input     start, busy, in_item              taken when start high, busy low
//  result    out_strobe, out_item              valid for one cycle, no stall
//  config    cfg_we, cfg_index, cfg_wdata      written when cfg_we high
//
//  clear and a put that scrolls sweep every cell of the screen. the screen
//  memory has one read and one write port, so scroll and clear sweep it at
//  one cell a cycle. after reset a clearing pass fills the screen with
//  spaces in colour 7; busy stays high until it ends, config writes are taken.
//  results cannot be stalled by the receiver.
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // controller
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // datapath
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- src/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencing state machine: item accept, execute, memory sweeps and result
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_READ   = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_SCROLL = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // state register, reset starts the power-on clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      S_INIT: begin
        ctrl.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.command)
          CMD_PUT: begin
            ctrl.put_exec = 1'b1;
            if (stat.put_scroll) begin
              ctrl.sweep_start = 1'b1;
              state_nxt        = S_SCROLL;
            end else begin
              ctrl.emit = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_CLEAR: begin
            ctrl.sweep_start = 1'b1;
            ctrl.fill_all    = 1'b1;
            state_nxt        = S_CLEAR;
          end
          CMD_READ: begin
            ctrl.read_issue = 1'b1;
            state_nxt       = S_READ;
          end
          default: begin
            // unused command: report the cursor only
            ctrl.emit = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        ctrl.emit      = 1'b1;
        ctrl.emit_read = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_CLEAR: begin
        ctrl.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          ctrl.emit = 1'b1;
          ctrl.home = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCROLL: begin
        ctrl.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          ctrl.emit          = 1'b1;
          ctrl.emit_scrolled = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- src/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// screen memory, cursor, colour registers, sweep pipeline and result register
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_ctrl_t              ctrl,
  output dp_stat_t              stat,
  output logic                  out_strobe,
  output out_item_t             out_item
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int COPY_END = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLUMNS);

  // colour registers
  logic [COLOUR_W-1:0] text_colour_r;
  logic [COLOUR_W-1:0] scroll_colour_r;

  // latched item
  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] char_r;
  logic [AW-1:0]     read_idx_r;
  logic              in_range_r;

  // cursor
  logic [RW-1:0] cursor_row_r, cursor_row_nxt;
  logic [CW-1:0] cursor_col_r, cursor_col_nxt;

  // sweep pipeline
  logic [AW-1:0]     sweep_r;
  logic              fill_mode_r;
  logic [CELL_W-1:0] fill_cell_r;
  logic              wr_valid_r;
  logic [AW-1:0]     wr_addr_r;
  logic              wr_fill_r;

  // memory ports
  logic [CELL_W-1:0] screen_mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              out_strobe_r;
  out_item_t         out_item_r, out_item_nxt;

  logic [AW-1:0] cur_idx;
  logic          is_newline;
  logic          row_last;
  logic          col_last;
  logic          advance_row;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_colour_r   <= RESET_TEXT_COLOUR;
      scroll_colour_r <= RESET_SCROLL_COLOUR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_COLOUR:   text_colour_r   <= cfg_wdata;
        REG_SCROLL_COLOUR: scroll_colour_r <= cfg_wdata;
        default:           text_colour_r   <= text_colour_r;
      endcase
    end
  end

  // item latch, read address and range worked out on accept
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r      <= in_item.command;
      char_r     <= in_item.char_code;
      read_idx_r <= AW'(in_item.read_row) * AW'(COLUMNS) + AW'(in_item.read_column);
      in_range_r <= (int'(in_item.read_row) < ROWS) && (int'(in_item.read_column) < COLUMNS);
    end
  end

  // cursor step for a put
  always_comb begin
    is_newline  = (char_r == NEWLINE_CODE);
    row_last    = (cursor_row_r == RW'(ROWS - 1));
    col_last    = (cursor_col_r == CW'(COLUMNS - 1));
    advance_row = is_newline | col_last;
    cur_idx     = AW'(cursor_row_r) * AW'(COLUMNS) + AW'(cursor_col_r);
  end

  always_comb begin
    cursor_row_nxt = cursor_row_r;
    cursor_col_nxt = cursor_col_r;
    priority if (ctrl.home) begin
      cursor_row_nxt = '0;
      cursor_col_nxt = '0;
    end else if (ctrl.put_exec) begin
      cursor_col_nxt = advance_row ? '0 : cursor_col_r + CW'(1);
      if (advance_row && !row_last) begin
        cursor_row_nxt = cursor_row_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_row_r <= '0;
      cursor_col_r <= '0;
    end else begin
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
    end
  end

  // sweep counter: reset leaves it ready for the power-on fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      fill_mode_r <= 1'b1;
      fill_cell_r <= {RESET_TEXT_COLOUR, SPACE_CODE};
      wr_valid_r  <= 1'b0;
    end else begin
      if (ctrl.sweep_start) begin
        sweep_r     <= '0;
        fill_mode_r <= ctrl.fill_all;
        fill_cell_r <= {(ctrl.fill_all ? text_colour_r : scroll_colour_r), SPACE_CODE};
      end else if (ctrl.sweep_step) begin
        sweep_r <= sweep_r + AW'(1);
      end
      wr_valid_r <= ctrl.sweep_step;
    end
  end

  // write stage of the sweep, in the cycle after the read
  always_ff @(posedge clk) begin
    wr_addr_r <= sweep_r;
    wr_fill_r <= fill_mode_r | (sweep_r >= AW'(COPY_END));
  end

  // memory port selection
  always_comb begin
    rd_addr   = ctrl.read_issue ? read_idx_r : sweep_r + AW'(COLUMNS);
    mem_we    = wr_valid_r | (ctrl.put_exec & ~is_newline);
    mem_waddr = wr_valid_r ? wr_addr_r : cur_idx;
    mem_wdata = wr_valid_r ? (wr_fill_r ? fill_cell_r : rdata_r) : {text_colour_r, char_r};
  end

  // screen memory, registered read
  always_ff @(posedge clk) begin
    rdata_r <= screen_mem[rd_addr];
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
  end

  // result register
  always_comb begin
    out_item_nxt.cell_entry    = (ctrl.emit_read && in_range_r) ? rdata_r : '0;
    out_item_nxt.cursor_row    = ROW_FIELD_W'(cursor_row_nxt);
    out_item_nxt.cursor_column = COL_FIELD_W'(cursor_col_nxt);
    out_item_nxt.scrolled      = ctrl.emit_scrolled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  // status to the controller
  always_comb begin
    stat.command    = cmd_r;
    stat.put_scroll = advance_row & row_last;
    stat.sweep_last = (sweep_r == AW'(CELLS - 1));
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- src/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks on item flow and results of the text console writer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int ROWS = DEF_ROWS
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // an accepted item keeps the block busy for at least the next cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept not followed by busy")

  // results only show once the block is free again
  `ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result while busy")

  // one result per item, never two in a row
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "back-to-back results")

  // a scroll always leaves the cursor on the last row
  `ASSERT_SAME(a_scroll_row, clk, rst_n, out_strobe && out_item.scrolled, out_item.cursor_row == ROW_FIELD_W'(ROWS - 1), "scroll off last row")

endmodule

bind text_console_writer_core tcw_checker #(.ROWS(ROWS)) u_tcw_checker (.*);
